[hw/rtl/rtlpm_pkg.sv]
// ----------------------------------------------------------------------------
// rtlpm_pkg
// Types, codes and sizes shared by the route table engine.
// ----------------------------------------------------------------------------
package rtlpm_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);

  localparam int IP_W   = 32;
  localparam int PORT_W = 8;
  localparam int MAC_W  = 48;
  localparam int HOPS_W = 8;
  localparam int LIFE_W = 16;

  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 64;

  localparam logic [LIFE_W-1:0] LIFE_FOREVER = '1;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_NOROUTE = 2'd1,
    STS_REJECT  = 2'd2,
    STS_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic [IP_W-1:0]   dest;
    logic [IP_W-1:0]   mask;
    logic [PORT_W-1:0] port;
    logic [MAC_W-1:0]  mac;
    logic [HOPS_W-1:0] hops;
    logic [LIFE_W-1:0] life;
  } entry_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [IP_W-1:0]   ip;
    logic [IP_W-1:0]   mask;
    logic [PORT_W-1:0] port;
    logic [MAC_W-1:0]  mac;
    logic [HOPS_W-1:0] hops;
    logic [LIFE_W-1:0] life;
  } req_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } ctl_sts_t;

endpackage

[hw/rtl/routing_table_lpm_engine_unit.sv]
// ----------------------------------------------------------------------------
// routing_table_lpm_engine_unit
// Longest-prefix-match route table with lookup, update and ageing commands.
// ----------------------------------------------------------------------------
// Every transaction sweeps all TABLE_ENTRIES (32) slots of the table memory,
// one slot per cycle, then passes the drain state, which finishes the last
// read, and the commit state, which waits until the output register is free.
// The result sits in an output register, so a new command is taken while the
// previous result still waits. Lookups return the matching route with the
// numerically largest mask; updates replace a route with the same key only
// when the new one is better, and without such a route fill a free slot;
// ticks age and expire. Commands are accepted only in the idle state.
// ----------------------------------------------------------------------------
module routing_table_lpm_engine_unit import rtlpm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // ip_address[31:0], net_mask[63:32], port_id[71:64], next_mac[119:72],
  // hop_count[127:120], life_ticks[143:128]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_port[7:0], out_mac[55:8], out_hops[63:56]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]            m_axis_tuser
);

  ctl_cmd_t          ctl_cmd;
  ctl_sts_t          ctl_sts;
  req_t              req;
  status_e           out_status;
  logic [PORT_W-1:0] out_port;
  logic [MAC_W-1:0]  out_mac;
  logic [HOPS_W-1:0] out_hops;

  assign req.cmd  = cmd_e'(s_axis_tuser);
  assign req.ip   = s_axis_tdata[31:0];
  assign req.mask = s_axis_tdata[63:32];
  assign req.port = s_axis_tdata[71:64];
  assign req.mac  = s_axis_tdata[119:72];
  assign req.hops = s_axis_tdata[127:120];
  assign req.life = s_axis_tdata[143:128];

  rtlpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (ctl_sts),
    .cmd_o      (ctl_cmd)
  );

  rtlpm_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (ctl_cmd),
    .sts_o        (ctl_sts),
    .req_i        (req),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_port_o   (out_port),
    .out_mac_o    (out_mac),
    .out_hops_o   (out_hops)
  );

  assign m_axis_tdata = {out_hops, out_mac, out_port};
  assign m_axis_tuser = out_status;

endmodule

[hw/rtl/rtlpm_ctrl.sv]
// ----------------------------------------------------------------------------
// rtlpm_ctrl
// Sequencer: accept a transaction, sweep the table, commit the result.
// ----------------------------------------------------------------------------
module rtlpm_ctrl import rtlpm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ctl_sts_t sts_i,
  output ctl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.scan_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.start  = in_valid_i;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_COMMIT: begin
        cmd_o.commit = sts_i.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

[hw/rtl/rtlpm_dpath.sv]
// ----------------------------------------------------------------------------
// rtlpm_dpath
// Table memory, per-slot evaluation, decision and output register.
// ----------------------------------------------------------------------------
module rtlpm_dpath import rtlpm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctl_cmd_t              cmd_i,
  output ctl_sts_t              sts_o,
  input  req_t                  req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output status_e               out_status_o,
  output logic [PORT_W-1:0]     out_port_o,
  output logic [MAC_W-1:0]      out_mac_o,
  output logic [HOPS_W-1:0]     out_hops_o
);

  entry_t                   mem_q [TABLE_ENTRIES];
  entry_t                   rd_q;
  logic                     rd_vld_q;
  logic [IDX_W-1:0]         rd_idx_q;
  logic [IDX_W-1:0]         cnt_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  req_t                     req_q;

  logic                     hit_q;
  logic [IP_W-1:0]          best_mask_q;
  logic [PORT_W-1:0]        best_port_q;
  logic [MAC_W-1:0]         best_mac_q;
  logic [HOPS_W-1:0]        best_hops_q;

  logic                     found_q;
  logic [IDX_W-1:0]         found_idx_q;
  logic [HOPS_W-1:0]        found_hops_q;
  logic [LIFE_W-1:0]        found_life_q;
  logic                     free_q;
  logic [IDX_W-1:0]         free_idx_q;

  logic                     out_valid_q;
  status_e                  out_status_q;
  logic [PORT_W-1:0]        out_port_q;
  logic [MAC_W-1:0]         out_mac_q;
  logic [HOPS_W-1:0]        out_hops_q;

  logic                     slot_ok;
  logic [IP_W-1:0]          key;
  logic                     lk_take;
  logic                     up_match;
  logic                     up_free;
  logic                     tk_en;
  logic [LIFE_W-1:0]        new_life;
  logic                     better;

  logic                     we;
  logic [IDX_W-1:0]         wa;
  entry_t                   wd;
  logic                     set_valid;
  status_e                  res_status;
  logic                     out_free;

  assign key      = req_q.ip & req_q.mask;
  assign slot_ok  = rd_vld_q && valid_q[rd_idx_q];

  assign lk_take  = (req_q.cmd == CMD_LOOKUP) && slot_ok &&
                    ((req_q.ip & rd_q.mask) == rd_q.dest) &&
                    (!hit_q || (rd_q.mask > best_mask_q));
  assign up_match = (req_q.cmd == CMD_UPDATE) && slot_ok && !found_q &&
                    (rd_q.dest == key) && (rd_q.mask == req_q.mask);
  assign up_free  = (req_q.cmd == CMD_UPDATE) && rd_vld_q &&
                    !valid_q[rd_idx_q] && !free_q;
  assign tk_en    = (req_q.cmd == CMD_TICK) && slot_ok;
  assign new_life = ($signed(rd_q.life) > $signed(16'sd0)) ? rd_q.life - 16'd1 : rd_q.life;

  assign better = (req_q.hops < found_hops_q) ||
                  ((req_q.hops == found_hops_q) &&
                   ((req_q.life == LIFE_FOREVER) ||
                    (!found_life_q[LIFE_W-1] &&
                     ($signed(req_q.life) > $signed(found_life_q)))));

  assign out_free = !out_valid_q || out_ready_i;

  // write port and commit decision
  always_comb begin
    we         = 1'b0;
    wa         = rd_idx_q;
    wd         = rd_q;
    set_valid  = 1'b0;
    res_status = STS_OK;
    if (tk_en) begin
      we      = 1'b1;
      wd.life = new_life;
    end
    if (cmd_i.commit) begin
      wd.dest = key;
      wd.mask = req_q.mask;
      wd.port = req_q.port;
      wd.mac  = req_q.mac;
      wd.hops = req_q.hops;
      wd.life = req_q.life;
      case (req_q.cmd)
        CMD_LOOKUP: begin
          res_status = hit_q ? STS_OK : STS_NOROUTE;
        end
        CMD_UPDATE: begin
          if (found_q) begin
            if (better) begin
              we        = 1'b1;
              set_valid = 1'b1;
              wa        = found_idx_q;
            end else begin
              res_status = STS_REJECT;
            end
          end else if (free_q) begin
            we        = 1'b1;
            set_valid = 1'b1;
            wa        = free_idx_q;
          end else begin
            res_status = STS_FULL;
          end
        end
        default: begin
          res_status = STS_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    if (cmd_i.scan) rd_q <= mem_q[cnt_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) req_q <= req_i;
    rd_idx_q <= cnt_q;
    if (lk_take) begin
      best_mask_q <= rd_q.mask;
      best_port_q <= rd_q.port;
      best_mac_q  <= rd_q.mac;
      best_hops_q <= rd_q.hops;
    end
    if (up_match) begin
      found_idx_q  <= rd_idx_q;
      found_hops_q <= rd_q.hops;
      found_life_q <= rd_q.life;
    end
    if (up_free) free_idx_q <= rd_idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      valid_q  <= '0;
      hit_q    <= 1'b0;
      found_q  <= 1'b0;
      free_q   <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan;
      if (cmd_i.start) begin
        cnt_q   <= '0;
        hit_q   <= 1'b0;
        found_q <= 1'b0;
        free_q  <= 1'b0;
      end else begin
        if (cmd_i.scan) cnt_q <= cnt_q + 1'b1;
        if (lk_take)    hit_q   <= 1'b1;
        if (up_match)   found_q <= 1'b1;
        if (up_free)    free_q  <= 1'b1;
      end
      if (tk_en && (new_life == '0)) valid_q[rd_idx_q] <= 1'b0;
      if (set_valid) valid_q[wa] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_status_q <= res_status;
      if ((req_q.cmd == CMD_LOOKUP) && hit_q) begin
        out_port_q <= best_port_q;
        out_mac_q  <= best_mac_q;
        out_hops_q <= best_hops_q;
      end else begin
        out_port_q <= '0;
        out_mac_q  <= '0;
        out_hops_q <= '0;
      end
    end
  end

  assign sts_o.scan_last = (cnt_q == IDX_W'(TABLE_ENTRIES - 1));
  assign sts_o.out_free  = out_free;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_port_o   = out_port_q;
  assign out_mac_o    = out_mac_q;
  assign out_hops_o   = out_hops_q;

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the longest-prefix-match route table engine.
// ----------------------------------------------------------------------------
// A queue of commands feeds a stream driver. Every accepted command is applied
// to a route table model in the bench, which queues the result it expects.
// A monitor compares each result transaction, field by field, with the oldest
// expected one. A directed opener covers the extremes and the replacement and
// ageing rules. Random phases follow, built from a pool of overlapping
// prefixes, with bursts of new routes that fill the table. The phases vary
// the source gaps and sink stalls, and one of them holds off the sink for a
// long stretch.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rtlpm_pkg::*;

  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int POOL_KEYS       = 12;
  localparam int ITEMS_PER_PHASE = 120;
  localparam int FILL_AT         = 40;
  localparam int FILL_BURST      = 24;

  typedef struct packed {
    status_e           status;
    logic [PORT_W-1:0] port;
    logic [MAC_W-1:0]  mac;
    logic [HOPS_W-1:0] hops;
  } route_rsp_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;

  req_t       pending_cmds[$];
  route_rsp_t expected_rsps[$];
  req_t       in_flight;

  logic                     rt_valid [TABLE_ENTRIES] = '{default: 1'b0};
  logic [IP_W-1:0]          rt_dest  [TABLE_ENTRIES];
  logic [IP_W-1:0]          rt_mask  [TABLE_ENTRIES];
  logic [PORT_W-1:0]        rt_port  [TABLE_ENTRIES];
  logic [MAC_W-1:0]         rt_mac   [TABLE_ENTRIES];
  logic [HOPS_W-1:0]        rt_hops  [TABLE_ENTRIES];
  logic signed [LIFE_W-1:0] rt_life  [TABLE_ENTRIES];

  logic [IP_W-1:0] pool_dest [POOL_KEYS];
  logic [IP_W-1:0] pool_mask [POOL_KEYS];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;
  bit hold_done;
  int hold_count;
  int watchdog       = 0;
  int mismatches     = 0;

  routing_table_lpm_engine_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ---- route table model ----

  function automatic void store_route(int idx, req_t c);
    rt_valid[idx] = 1'b1;
    rt_dest[idx]  = c.ip & c.mask;
    rt_mask[idx]  = c.mask;
    rt_port[idx]  = c.port;
    rt_mac[idx]   = c.mac;
    rt_hops[idx]  = c.hops;
    rt_life[idx]  = c.life;
  endfunction

  function automatic route_rsp_t route_table_step(req_t c);
    route_rsp_t               r;
    logic                     hit;
    logic                     found;
    logic                     better;
    logic [IP_W-1:0]          best;
    logic [IP_W-1:0]          key;
    logic signed [LIFE_W-1:0] new_life;
    int                       sel;
    int                       free_slot;
    r         = '0;
    r.status  = STS_OK;
    hit       = 1'b0;
    found     = 1'b0;
    best      = '0;
    sel       = 0;
    free_slot = -1;
    key       = c.ip & c.mask;
    new_life  = c.life;
    case (c.cmd)
      CMD_LOOKUP: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (rt_valid[i] && (c.ip & rt_mask[i]) == rt_dest[i]) begin
            if (!hit || rt_mask[i] > best) begin
              best = rt_mask[i];
              sel  = i;
            end
            hit = 1'b1;
          end
        end
        if (hit) begin
          r.port = rt_port[sel];
          r.mac  = rt_mac[sel];
          r.hops = rt_hops[sel];
        end else begin
          r.status = STS_NOROUTE;
        end
      end
      CMD_UPDATE: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (!found) begin
            if (rt_valid[i]) begin
              if (rt_dest[i] == key && rt_mask[i] == c.mask) begin
                found  = 1'b1;
                better = c.hops < rt_hops[i] ||
                         (c.hops == rt_hops[i] &&
                          (c.life == LIFE_FOREVER ||
                           (rt_life[i] >= 0 && new_life > rt_life[i])));
                if (better) begin
                  store_route(i, c);
                end else begin
                  r.status = STS_REJECT;
                end
              end
            end else if (free_slot < 0) begin
              free_slot = i;
            end
          end
        end
        if (!found) begin
          if (free_slot < 0) begin
            r.status = STS_FULL;
          end else begin
            store_route(free_slot, c);
          end
        end
      end
      CMD_TICK: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (rt_valid[i]) begin
            if (rt_life[i] > 0) begin
              rt_life[i] = rt_life[i] - 16'sd1;
            end
            if (rt_life[i] == 0) begin
              rt_valid[i] = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---- stimulus ----

  function automatic req_t route_req(cmd_e cmd, logic [IP_W-1:0] ip, logic [IP_W-1:0] mask,
                                     logic [PORT_W-1:0] port, logic [MAC_W-1:0] mac,
                                     logic [HOPS_W-1:0] hops, logic [LIFE_W-1:0] life);
    req_t c;
    c.cmd  = cmd;
    c.ip   = ip;
    c.mask = mask;
    c.port = port;
    c.mac  = mac;
    c.hops = hops;
    c.life = life;
    return c;
  endfunction

  function automatic logic [IP_W-1:0] prefix_mask(int len);
    return (len == 0) ? '0 : ({IP_W{1'b1}} << (IP_W - len));
  endfunction

  function automatic req_t random_fields();
    req_t c;
    c.cmd  = CMD_LOOKUP;
    c.ip   = $urandom;
    c.mask = $urandom;
    c.port = PORT_W'($urandom);
    c.mac  = MAC_W'({$urandom, $urandom});
    c.hops = HOPS_W'($urandom);
    c.life = LIFE_W'($urandom);
    return c;
  endfunction

  // new key with a short life, so the table drains again on ticks
  function automatic req_t fresh_route(req_t c);
    c.cmd  = CMD_UPDATE;
    c.mask = prefix_mask($urandom_range(32, 8));
    c.life = LIFE_W'($urandom_range(6));
    return c;
  endfunction

  function automatic req_t random_route_cmd();
    req_t c;
    int   pick;
    int   kind;
    int   k;
    c    = random_fields();
    pick = $urandom_range(99);
    k    = $urandom_range(POOL_KEYS - 1);
    if (pick < 40) begin
      if ($urandom_range(3) != 0) begin
        c.ip = pool_dest[k] | (c.ip & ~pool_mask[k]);
      end
    end else if (pick < 80) begin
      if ($urandom_range(99) < 65) begin
        c.cmd  = CMD_UPDATE;
        c.ip   = pool_dest[k] | (c.ip & ~pool_mask[k]);
        c.mask = pool_mask[k];
        kind   = $urandom_range(99);
        if (kind < 25) begin
          c.life = LIFE_FOREVER;
        end else if (kind < 35) begin
          c.life = LIFE_W'($urandom_range(16'hFFFE, 16'h8000));
        end else if (kind < 60) begin
          c.life = LIFE_W'($urandom_range(6));
        end else if (kind < 80) begin
          c.life = LIFE_W'($urandom_range(40, 7));
        end else begin
          c.life = LIFE_W'($urandom_range(16'h7FFF));
        end
        if ($urandom_range(99) < 70) begin
          c.hops = HOPS_W'($urandom_range(3));
        end
      end else begin
        c = fresh_route(c);
      end
    end else if (pick < 97) begin
      c.cmd = CMD_TICK;
    end else begin
      c.cmd = CMD_NONE;
    end
    return c;
  endfunction

  task automatic wait_drained();
    do begin
      @(negedge clk_i);
    end while (pending_cmds.size() != 0 || s_axis_tvalid || expected_rsps.size() != 0);
  endtask

  task automatic run_phase(int send_pct, int stall_pct, bit long_hold);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    hold_req       = long_hold;
    for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
      if (n >= FILL_AT && n < FILL_AT + FILL_BURST) begin
        pending_cmds.push_back(fresh_route(random_fields()));
      end else begin
        pending_cmds.push_back(random_route_cmd());
      end
    end
    wait_drained();
  endtask

  // ---- source side ----

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_rsps.push_back(route_table_step(in_flight));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_flight = pending_cmds.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {in_flight.life, in_flight.hops, in_flight.mac,
                            in_flight.port, in_flight.mask, in_flight.ip};
          s_axis_tuser  <= in_flight.cmd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---- sink side ----

  task automatic check_route_rsp();
    route_rsp_t want;
    if (expected_rsps.size() == 0) begin
      $error("result transaction with no command outstanding, status %0d", m_axis_tuser);
      mismatches++;
    end else begin
      want = expected_rsps.pop_front();
      if (m_axis_tuser !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
        mismatches++;
      end
      if (m_axis_tdata[7:0] !== want.port) begin
        $error("out_port: expected %0d, got %0d", want.port, m_axis_tdata[7:0]);
        mismatches++;
      end
      if (m_axis_tdata[55:8] !== want.mac) begin
        $error("out_mac: expected %h, got %h", want.mac, m_axis_tdata[55:8]);
        mismatches++;
      end
      if (m_axis_tdata[63:56] !== want.hops) begin
        $error("out_hops: expected %0d, got %0d", want.hops, m_axis_tdata[63:56]);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_count    <= 0;
      hold_done     <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_route_rsp();
      end
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        hold_count    <= hold_count + 1;
        if (hold_count == HOLD_CYCLES - 1) begin
          hold_done <= 1'b1;
        end
      end else begin
        m_axis_tready <= $urandom_range(99) >= recv_stall_pct;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        watchdog <= 0;
      end else if (watchdog == WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        watchdog <= watchdog + 1;
      end
    end
  end

  // ---- sequence ----

  initial begin
    logic [IP_W-1:0] net_base;
    logic [IP_W-1:0] msk;
    net_base = $urandom;
    for (int k = 0; k < POOL_KEYS; k++) begin
      msk          = (k < 2) ? IP_W'($urandom) : prefix_mask($urandom_range(32, 4));
      pool_mask[k] = msk;
      pool_dest[k] = ((k % 3 == 0) ? IP_W'($urandom) : net_base) & msk;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    pending_cmds.push_back(route_req(CMD_LOOKUP, '0, '0, '0, '0, '0, '0));
    pending_cmds.push_back(route_req(CMD_TICK, '0, '0, '0, '0, '0, '0));
    pending_cmds.push_back(route_req(CMD_NONE, '1, '1, '1, '1, '1, '1));
    pending_cmds.push_back(route_req(CMD_UPDATE, 32'hC0A8_0105, 32'hFFFF_FF00, 8'd0,
                                     '0, 8'd5, 16'h7FFF));
    pending_cmds.push_back(route_req(CMD_UPDATE, 32'hC0A8_1234, 32'hFFFF_0000, 8'd2,
                                     48'h0123_4567_89AB, 8'd3, 16'd10));
    // default route
    pending_cmds.push_back(route_req(CMD_UPDATE, 32'hDEAD_BEEF, '0, 8'hFF, '1, 8'hFF, 16'd3));
    // host route inserted with zero life
    pending_cmds.push_back(route_req(CMD_UPDATE, '1, '1, 8'd7, 48'h0000_0000_0707, 8'd0,
                                     16'd0));
    pending_cmds.push_back(route_req(CMD_LOOKUP, 32'hC0A8_0177, '0, '0, '0, '0, '0));
    pending_cmds.push_back(route_req(CMD_LOOKUP, 32'hC0A8_FF01, '0, '0, '0, '0, '0));
    pending_cmds.push_back(route_req(CMD_LOOKUP, 32'h0102_0304, '0, '0, '0, '0, '0));
    pending_cmds.push_back(route_req(CMD_LOOKUP, '1, '0, '0, '0, '0, '0));
    // more hops: rejected
    pending_cmds.push_back(route_req(CMD_UPDATE, 32'hC0A8_0100, 32'hFFFF_FF00, 8'd8,
                                     48'h0808, 8'd6, LIFE_FOREVER));
    // equal hops, never expires: replaces
    pending_cmds.push_back(route_req(CMD_UPDATE, 32'hC0A8_01AA, 32'hFFFF_FF00, 8'd9,
                                     48'h0909, 8'd5, LIFE_FOREVER));
    // equal hops, shorter life: rejected, then longer life: replaces
    pending_cmds.push_back(route_req(CMD_UPDATE, 32'hC0A8_0000, 32'hFFFF_0000, 8'd4,
                                     48'h0404, 8'd3, 16'd5));
    pending_cmds.push_back(route_req(CMD_UPDATE, 32'hC0A8_0000, 32'hFFFF_0000, 8'd5,
                                     48'h0505, 8'd3, 16'd20));
    // old entry never expires: finite life rejected
    pending_cmds.push_back(route_req(CMD_UPDATE, 32'hC0A8_0101, 32'hFFFF_FF00, 8'd6,
                                     48'h0606, 8'd5, 16'd100));
    // fewer hops always wins
    pending_cmds.push_back(route_req(CMD_UPDATE, 32'hC0A8_0000, 32'hFFFF_0000, 8'd10,
                                     48'h0A0A, 8'd2, 16'd1));
    pending_cmds.push_back(route_req(CMD_TICK, '1, '1, '1, '1, '1, '1));
    pending_cmds.push_back(route_req(CMD_LOOKUP, '1, '0, '0, '0, '0, '0));
    // top-bit mask must beat 0x7fffffff
    pending_cmds.push_back(route_req(CMD_UPDATE, '1, 32'h8000_0000, 8'd11, 48'h0B0B, 8'd1,
                                     LIFE_FOREVER));
    pending_cmds.push_back(route_req(CMD_UPDATE, '1, 32'h7FFF_FFFF, 8'd12, 48'h0C0C, 8'd1,
                                     LIFE_FOREVER));
    pending_cmds.push_back(route_req(CMD_LOOKUP, '1, '0, '0, '0, '0, '0));
    // negative life never ages
    pending_cmds.push_back(route_req(CMD_UPDATE, 32'h1234_5678, 32'hFFFF_8000, 8'd13,
                                     48'h0D0D, 8'd0, 16'h8000));
    pending_cmds.push_back(route_req(CMD_TICK, '0, '0, '0, '0, '0, '0));
    pending_cmds.push_back(route_req(CMD_LOOKUP, 32'h1234_5678, '0, '0, '0, '0, '0));
    pending_cmds.push_back(route_req(CMD_LOOKUP, 32'hC0A8_FF01, '0, '0, '0, '0, '0));
    wait_drained();

    run_phase(0, 0, 1'b1);
    run_phase(54, 0, 1'b0);
    run_phase(0, 54, 1'b0);
    run_phase(29, 29, 1'b0);

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
